>>> hw/rtl/upscl_pkg.sv
// ----------------------------------------------------------------------------
// upscl_pkg
// Shared types and constants of the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package upscl_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int COORD_W = 11;
  // Source position carried to the back end; 2*pos fills an output coordinate.
  localparam int POS_W   = COORD_W - 1;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Block flags, in emission order.
  localparam int BLK_UP_LEFT  = 0;
  localparam int BLK_UP_HERE  = 1;
  localparam int BLK_LOW_LEFT = 2;
  localparam int BLK_LOW_HERE = 3;
  localparam int NUM_BLK      = 4;

  typedef struct packed {
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
    logic [PIX_W-1:0]   ul;
    logic [PIX_W-1:0]   above;
    logic [PIX_W-1:0]   lf;
    logic [PIX_W-1:0]   px;
    logic [NUM_BLK-1:0] blocks;
    logic               frame_end;
  } job_t;

endpackage

>>> hw/rtl/image_upscale_2x_linear_top.sv
// ----------------------------------------------------------------------------
// image_upscale_2x_linear_top
// Streaming 2x bilinear upscaler for 8-bit raster frames.
// ----------------------------------------------------------------------------
// Source pixels come in on the pixel channel (pixel_valid / pixel_stall) in
// raster order. Each request yields 0, 4, 8 or 16 output pixels on the result
// channel (result_valid / result_stall), tagged with their row and column in
// the doubled frame; last_of_run marks the last output of a source pixel and
// frame_done the last of the frame. First-row pixels of a multi-row frame
// give no output; their blocks come out with the pixels of the next row.
// Frame size is set over the cfg port (index 0 width, 1 height); a write
// restarts the frame and is meant for idle periods only. cfg_ready is high.
// Throughput: one pixel per cycle enters while the 4-entry job queue has
// room; the back end sends one output pixel per cycle while result_stall is
// low, so the sustained rate is set by the single result port.
// Reset empties the pipeline and queue, sets both sizes to 256 and starts at
// the top-left pixel. The previous row lives in a MAX_WIDTH-entry RAM that
// needs no clearing. While result_stall is high the output register holds
// and the queue fills, after which pixel_stall rises.
// ----------------------------------------------------------------------------
module image_upscale_2x_linear_top import upscl_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [PIX_W-1:0]   pixel,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [PIX_W-1:0]   value,
  output logic               last_of_run,
  output logic               frame_done
);

  job_t front_job;
  job_t head_job;
  logic front_job_valid;
  logic queue_full;
  logic queue_not_empty;
  logic queue_pop;

  assign cfg_ready = 1'b1;

  upscl_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .job_valid   (front_job_valid),
    .job         (front_job),
    .queue_full  (queue_full)
  );

  upscl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_job_valid),
    .push_job  (front_job),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .head      (head_job)
  );

  upscl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (queue_not_empty),
    .q_head       (head_job),
    .q_pop        (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .value        (value),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

endmodule

>>> hw/rtl/upscl_front.sv
// ----------------------------------------------------------------------------
// upscl_front
// Takes source pixels, keeps the previous row and the position counters, and
// turns each pixel that completes 2x2 output blocks into a job naming them.
// ----------------------------------------------------------------------------
module upscl_front import upscl_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic [PIX_W-1:0] pixel,
  output logic             job_valid,
  output job_t             job,
  input  logic             queue_full
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [XW-1:0]    wm1;
  logic [YW-1:0]    hm1;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [PIX_W-1:0] lf;
  logic [PIX_W-1:0] ul;
  logic [PIX_W-1:0] row_store [MAX_WIDTH];
  logic [PIX_W-1:0] above;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic             cfg_write;

  // second stage: row store data is ready here
  logic             b_valid;
  logic [POS_W-1:0] b_x;
  logic [POS_W-1:0] b_y;
  logic             b_first_col;
  logic             b_first_row;
  logic             b_last_col;
  logic             b_last_row;
  logic [PIX_W-1:0] b_px;
  logic [PIX_W-1:0] b_lf;
  logic             b_has_work;
  logic             b_fire;

  always_comb begin
    if (frame_width == '0) begin
      wm1 = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(frame_width - CFG_W'(1));
    end
    if (frame_height == '0) begin
      hm1 = '0;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(frame_height - CFG_W'(1));
    end
  end

  assign last_col  = (x == wm1);
  assign last_row  = (y == hm1);
  assign cfg_write = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                                   (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    job.blocks[BLK_UP_LEFT]  = !b_first_row && !b_first_col;
    job.blocks[BLK_UP_HERE]  = !b_first_row && b_last_col;
    job.blocks[BLK_LOW_LEFT] = b_last_row && !b_first_col;
    job.blocks[BLK_LOW_HERE] = b_last_row && b_last_col;
    job.y         = b_y;
    job.x         = b_x;
    job.ul        = ul;
    job.above     = above;
    job.lf        = b_lf;
    job.px        = b_px;
    job.frame_end = b_last_row && b_last_col;
  end

  assign b_has_work  = |job.blocks;
  assign job_valid   = b_valid && b_has_work;
  assign b_fire      = b_valid && (!b_has_work || !queue_full);
  assign pixel_stall = b_valid && b_has_work && queue_full;
  assign accept      = pixel_valid && !pixel_stall;

  // read-first: a pixel sees the entry left by the row above
  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[x] <= pixel;
      above        <= row_store[x];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_x         <= POS_W'(x);
      b_y         <= POS_W'(y);
      b_first_col <= (x == '0);
      b_first_row <= (y == '0);
      b_last_col  <= last_col;
      b_last_row  <= last_row;
      b_px        <= pixel;
      b_lf        <= lf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(256);
      frame_height <= CFG_W'(256);
      x            <= '0;
      y            <= '0;
      lf           <= '0;
      ul           <= '0;
      b_valid      <= 1'b0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire && !cfg_write) begin
        ul <= b_last_col ? '0 : above;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
        x  <= '0;
        y  <= '0;
        lf <= '0;
        ul <= '0;
      end else if (accept) begin
        if (last_col) begin
          x  <= '0;
          lf <= '0;
          y  <= last_row ? '0 : y + YW'(1);
        end else begin
          x  <= x + XW'(1);
          lf <= pixel;
        end
      end
    end
  end

endmodule

>>> hw/rtl/upscl_queue.sv
// ----------------------------------------------------------------------------
// upscl_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module upscl_queue import upscl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/upscl_back.sv
// ----------------------------------------------------------------------------
// upscl_back
// Walks the blocks of each job and emits their four pixels through the output
// register, one per cycle while result_stall does not hold it.
// ----------------------------------------------------------------------------
module upscl_back import upscl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  job_t               q_head,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [PIX_W-1:0]   value,
  output logic               last_of_run,
  output logic               frame_done
);

  job_t               cur;
  logic               cur_valid;
  logic [NUM_BLK-1:0] mask;
  logic [1:0]         sub;
  logic [1:0]         blk;
  logic [NUM_BLK-1:0] mask_next;
  logic               adv;
  logic               last_out;
  logic [PIX_W-1:0]   tl, tr, bl, br;
  logic [PIX_W:0]     sum_top, sum_bot, sum_left, sum_mid;
  logic [PIX_W-1:0]   htop, hbot, val;
  logic [POS_W-1:0]   a, b;

  always_comb begin
    if (mask[BLK_UP_LEFT]) begin
      blk = 2'(BLK_UP_LEFT);
    end else if (mask[BLK_UP_HERE]) begin
      blk = 2'(BLK_UP_HERE);
    end else if (mask[BLK_LOW_LEFT]) begin
      blk = 2'(BLK_LOW_LEFT);
    end else begin
      blk = 2'(BLK_LOW_HERE);
    end
    mask_next      = mask;
    mask_next[blk] = 1'b0;
  end

  always_comb begin
    case (blk)
      2'(BLK_UP_LEFT): begin
        tl = cur.ul;    tr = cur.above; bl = cur.lf; br = cur.px;
      end
      2'(BLK_UP_HERE): begin
        tl = cur.above; tr = cur.above; bl = cur.px; br = cur.px;
      end
      2'(BLK_LOW_LEFT): begin
        tl = cur.lf;    tr = cur.px;    bl = cur.lf; br = cur.px;
      end
      default: begin
        tl = cur.px;    tr = cur.px;    bl = cur.px; br = cur.px;
      end
    endcase
    // upper blocks sit one source row back, left blocks one column back
    a = blk[1] ? cur.y : cur.y - POS_W'(1);
    b = blk[0] ? cur.x : cur.x - POS_W'(1);
  end

  assign sum_top  = {1'b0, tl} + {1'b0, tr};
  assign sum_bot  = {1'b0, bl} + {1'b0, br};
  assign sum_left = {1'b0, tl} + {1'b0, bl};
  assign htop     = sum_top[PIX_W:1];
  assign hbot     = sum_bot[PIX_W:1];
  assign sum_mid  = {1'b0, htop} + {1'b0, hbot};

  always_comb begin
    case (sub)
      2'd0:    val = tl;
      2'd1:    val = htop;
      2'd2:    val = sum_left[PIX_W:1];
      default: val = sum_mid[PIX_W:1];
    endcase
  end

  assign adv      = cur_valid && (!result_valid || !result_stall);
  assign last_out = (sub == 2'd3) && (mask_next == '0);
  assign q_pop    = q_not_empty && (!cur_valid || (adv && last_out));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (adv) begin
      out_row     <= {a, sub[1]};
      out_col     <= {b, sub[0]};
      value       <= val;
      last_of_run <= last_out;
      frame_done  <= last_out && cur.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      mask         <= '0;
      sub          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        mask      <= q_head.blocks;
        sub       <= '0;
      end else if (adv) begin
        sub <= sub + 2'd1;
        if (sub == 2'd3) begin
          mask <= mask_next;
          if (last_out) begin
            cur_valid <= 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/upscl_checker.sv
// ----------------------------------------------------------------------------
// upscl_checker
// Port-level checks on the result channel of the upscaler.
// ----------------------------------------------------------------------------
module upscl_checker import upscl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic [COORD_W-1:0] out_row,
  input logic [COORD_W-1:0] out_col,
  input logic [PIX_W-1:0]   value,
  input logic               last_of_run,
  input logic               frame_done
);

  // a stalled request keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_row) &&
      $stable(out_col) && $stable(value) && $stable(last_of_run) &&
      $stable(frame_done))
    else $error("result changed while stalled");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // runs are whole 2x2 blocks, so they end on the odd-odd corner
  a_run_corner: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |-> out_row[0] && out_col[0])
    else $error("run ended inside a block");

  // within a block the top-left pixel is followed by its right neighbor
  a_block_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !out_row[0] && !out_col[0] |=>
      !result_valid || (!out_row[0] && out_col[0]))
    else $error("block pixels out of order");

endmodule

bind image_upscale_2x_linear_top upscl_checker u_upscl_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_row      (out_row),
  .out_col      (out_col),
  .value        (value),
  .last_of_run  (last_of_run),
  .frame_done   (frame_done)
);
